>>> hw/rtl/multi_output_strided_fir_macros.svh
// Assertion macros for the filter bank RTL.
`ifndef MULTI_OUTPUT_STRIDED_FIR_MACROS_SVH
`define MULTI_OUTPUT_STRIDED_FIR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MSFIR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define MSFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/msfir_pkg.sv
// Package: beat types, register indexes and widths of the strided FIR bank.
`timescale 1ns / 1ps

package msfir_pkg;

    localparam int SMP_W    = 16;
    localparam int COEF_W   = 16;
    localparam int RES_W    = 24;
    localparam int NF_REG_W = 4;
    localparam int NT_REG_W = 7;
    localparam int ST_REG_W = 5;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NUM_FILTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_STRIDE  = 2'd2;

    // Operation codes of an input beat
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [SMP_W-1:0]  sample;
        logic [2:0]               coef_filter;
        logic [5:0]               coef_tap;
        logic signed [COEF_W-1:0] coef_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [RES_W-1:0] out_value;
        logic [2:0]              out_filter;
        logic                    last;
    } t_out_beat;

    // Delay line control
    typedef struct packed {
        logic wr;
        logic issue;
    } t_dl_ctl;

    // Multiply-accumulate control
    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

endpackage

>>> hw/rtl/msfir_dline.sv
// Circular delay line memory with read address walk and fill tracking.
`timescale 1ns / 1ps

module msfir_dline #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msfir_pkg::t_dl_ctl                  i_ctl,
    input  logic [msfir_pkg::SMP_W-1:0]         i_wr_data,
    input  logic [msfir_pkg::ST_REG_W-1:0]      i_stride,
    output logic [msfir_pkg::SMP_W-1:0]         o_rd_data
);
    import msfir_pkg::*;

    localparam int AD_W   = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AD_W:0]   DEPTH_X = (AD_W + 1)'(BUFFER_DEPTH);
    localparam logic [AD_W-1:0] LAST_AD = AD_W'(BUFFER_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL  = FILL_W'(BUFFER_DEPTH);

    logic [SMP_W-1:0]  r_mem [BUFFER_DEPTH];
    logic [SMP_W-1:0]  r_q;
    logic              r_rd_ok;
    logic [AD_W-1:0]   r_wp;
    logic [FILL_W-1:0] r_fill;
    logic [AD_W-1:0]   r_rd_addr;
    logic [AD_W-1:0]   r_off;
    logic [AD_W-1:0]   n_rd_addr;
    logic [AD_W-1:0]   n_off;
    logic [AD_W:0]     w_st;
    logic [AD_W:0]     w_off_sum;
    logic [AD_W:0]     w_rd_x;
    logic [AD_W:0]     w_rd_sub;

    // Step the tap offset and read address by one stride, modulo the depth
    always_comb begin
        w_st      = (AD_W + 1)'(i_stride);
        w_off_sum = {1'b0, r_off} + w_st;
        w_rd_x    = {1'b0, r_rd_addr};
        if (w_off_sum >= DEPTH_X) begin
            w_off_sum = w_off_sum - DEPTH_X;
        end
        if (w_rd_x >= w_st) begin
            w_rd_sub = w_rd_x - w_st;
        end else begin
            w_rd_sub = w_rd_x + DEPTH_X - w_st;
        end
        n_off     = w_off_sum[AD_W-1:0];
        n_rd_addr = w_rd_sub[AD_W-1:0];
    end

    // Write position, fill count and read walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_wp      <= (r_wp == LAST_AD) ? '0 : r_wp + 1'b1;
                r_fill    <= (r_fill == FULL) ? r_fill : r_fill + 1'b1;
                r_rd_addr <= r_wp;
                r_off     <= '0;
            end
            if (i_ctl.issue) begin
                // An entry never written since reset reads as zero
                r_rd_ok   <= FILL_W'(r_off) < r_fill;
                r_rd_addr <= n_rd_addr;
                r_off     <= n_off;
            end
        end
    end

    // Sample memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (i_ctl.issue) begin
            r_q <= r_mem[r_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_q : '0;

endmodule

>>> hw/rtl/msfir_coef.sv
// Coefficient memory: one row per tap, one lane per filter.
`timescale 1ns / 1ps

module msfir_coef #(
    parameter int NUM_FILTERS = 8,
    parameter int MAX_TAPS    = 64
) (
    input  logic                                                i_clk,
    input  logic                                                i_wr_en,
    input  logic [((NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1)-1:0] i_wr_lane,
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0]  i_wr_addr,
    input  logic [msfir_pkg::COEF_W-1:0]                        i_wr_data,
    input  logic                                                i_rd_en,
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0]  i_rd_addr,
    output logic [NUM_FILTERS-1:0][msfir_pkg::COEF_W-1:0]       o_rd_data
);
    import msfir_pkg::*;

    logic [NUM_FILTERS-1:0][COEF_W-1:0] r_mem [MAX_TAPS];
    logic [NUM_FILTERS-1:0][COEF_W-1:0] r_q;

    // Lane-enabled write, full-row registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_lane] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

>>> hw/rtl/msfir_mac.sv
// Per-filter multiply-accumulate lanes with scaling and saturation.
`timescale 1ns / 1ps

module msfir_mac #(
    parameter int NUM_FILTERS = 8,
    parameter int MAX_TAPS    = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  msfir_pkg::t_mac_ctl                           i_ctl,
    input  logic [msfir_pkg::SMP_W-1:0]                   i_smp,
    input  logic [NUM_FILTERS-1:0][msfir_pkg::COEF_W-1:0] i_coef,
    output logic [NUM_FILTERS-1:0][msfir_pkg::RES_W-1:0]  o_res
);
    import msfir_pkg::*;

    localparam int PROD_W = SMP_W + COEF_W;
    localparam int GROW_W = PROD_W + 1 + $clog2(MAX_TAPS);
    localparam int ACC_W  = (GROW_W > 38) ? GROW_W : 38;
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};

    logic r_v1;
    logic r_v2;
    logic signed [PROD_W-1:0] r_prod [NUM_FILTERS];
    logic signed [ACC_W-1:0]  r_acc  [NUM_FILTERS];

    // Track taps through memory read and multiply stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    for (genvar f = 0; f < NUM_FILTERS; f++) begin : g_lane
        logic [ACC_W-38:0] w_hi;

        // Multiply, then accumulate one tap per cycle
        always_ff @(posedge i_clk) begin
            if (r_v1) begin
                r_prod[f] <= $signed(i_coef[f]) * $signed(i_smp);
            end
            if (i_ctl.clear) begin
                r_acc[f] <= '0;
            end else if (r_v2) begin
                r_acc[f] <= r_acc[f] + ACC_W'(r_prod[f]);
            end
        end

        // Floor shift by 14, clamp to the 24-bit range
        always_comb begin
            w_hi = r_acc[f][ACC_W-1:37];
            if ((&w_hi) || !(|w_hi)) begin
                o_res[f] = r_acc[f][37:14];
            end else begin
                o_res[f] = r_acc[f][ACC_W-1] ? RES_MIN : RES_MAX;
            end
        end
    end

endmodule

>>> hw/rtl/msfir_obuf.sv
// Result bank that hands out one filter result per output beat.
`timescale 1ns / 1ps

module msfir_obuf #(
    parameter int NUM_FILTERS = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic [$clog2(NUM_FILTERS + 1)-1:0]            i_nf,
    input  logic [NUM_FILTERS-1:0][msfir_pkg::RES_W-1:0]  i_res,
    output logic                                          o_busy,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output msfir_pkg::t_out_beat                          o_out
);
    import msfir_pkg::*;

    localparam int FC_W = $clog2(NUM_FILTERS + 1);
    localparam int FI_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    logic [NUM_FILTERS-1:0][RES_W-1:0] r_bank;
    logic [FI_W-1:0] r_idx;
    logic [FC_W-1:0] r_nf;
    logic            r_active;
    logic            w_last;

    assign w_last = ((FC_W + 1)'(r_idx) + 1'b1) == (FC_W + 1)'(r_nf);

    // Load the bank, advance the index on each taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (r_active && i_out_ready) begin
            if (w_last) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bank <= i_res;
            r_nf   <= i_nf;
        end
    end

    assign o_busy            = r_active;
    assign o_out_valid       = r_active;
    assign o_out.out_value   = r_bank[r_idx];
    assign o_out.out_filter  = 3'(r_idx);
    assign o_out.last        = w_last;

endmodule

>>> hw/rtl/multi_output_strided_fir.sv
// Top level of the strided multi-output FIR filter bank.
`timescale 1ns / 1ps
`include "multi_output_strided_fir_macros.svh"

//  channel   direction  handshake                 payload
//  cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//  in        in         i_in_valid / o_in_ready   i_in  (t_in_beat)
//  out       out        o_out_valid / i_out_ready o_out (t_out_beat)
//
//  A sample beat walks the taps in S_RUN, one tap per cycle for all filters at
//  once, set by the single read port of the delay line and coefficient memories,
//  then waits out the read, multiply and accumulate stages and loads the bank.
//  A coefficient beat leaves the engine idle. Results leave one per beat from a bank,
//  so the next beat is taken while results still drain; the engine holds if they do.
//  Reset is synchronous; the delay line reads as zero until written via a fill count.

module multi_output_strided_fir #(
    parameter int NUM_FILTERS  = 8,
    parameter int MAX_TAPS     = 64,
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msfir_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [msfir_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  msfir_pkg::t_in_beat                 i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output msfir_pkg::t_out_beat                o_out
);
    import msfir_pkg::*;

    localparam int FC_W   = $clog2(NUM_FILTERS + 1);
    localparam int FI_W   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCNT_W = $clog2(MAX_TAPS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [TCNT_W-1:0]     r_j;
    logic [NF_REG_W-1:0]   r_num_filters;
    logic [NT_REG_W-1:0]   r_num_taps;
    logic [ST_REG_W-1:0]   r_tap_stride;

    logic [FC_W-1:0]       w_nf;
    logic [TCNT_W-1:0]     w_nt;
    logic [ST_REG_W-1:0]   w_st;
    logic                  w_in_acc;
    logic                  w_smp;
    logic                  w_coef_we;
    logic                  w_issue;
    logic                  w_last_tap;
    logic                  w_load;
    logic                  w_ob_busy;
    t_dl_ctl               w_dl_ctl;
    t_mac_ctl              w_mac_ctl;
    logic [SMP_W-1:0]      w_smp_rd;
    logic [NUM_FILTERS-1:0][COEF_W-1:0] w_coef_rd;
    logic [NUM_FILTERS-1:0][RES_W-1:0]  w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_filters <= NF_REG_W'(8);
            r_num_taps    <= NT_REG_W'(64);
            r_tap_stride  <= ST_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_FILTERS: r_num_filters <= i_cfg_data[NF_REG_W-1:0];
                REG_NUM_TAPS:    r_num_taps    <= i_cfg_data[NT_REG_W-1:0];
                REG_TAP_STRIDE:  r_tap_stride  <= i_cfg_data[ST_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp register values to the usable range
    always_comb begin
        if (r_num_filters == '0) begin
            w_nf = FC_W'(1);
        end else if (32'(r_num_filters) > NUM_FILTERS) begin
            w_nf = FC_W'(NUM_FILTERS);
        end else begin
            w_nf = FC_W'(r_num_filters);
        end
        if (r_num_taps == '0) begin
            w_nt = TCNT_W'(1);
        end else if (32'(r_num_taps) > MAX_TAPS) begin
            w_nt = TCNT_W'(MAX_TAPS);
        end else begin
            w_nt = TCNT_W'(r_num_taps);
        end
        w_st = (r_tap_stride == '0) ? ST_REG_W'(1) : r_tap_stride;
    end

    // Beat decode
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_smp      = w_in_acc && (i_in.op == OP_SAMPLE);
    assign w_coef_we  = w_in_acc && (i_in.op == OP_COEF)
                        && (32'(i_in.coef_filter) < NUM_FILTERS)
                        && (32'(i_in.coef_tap) < MAX_TAPS);
    assign w_issue    = (r_state == S_RUN);
    assign w_last_tap = (TCNT_W'(r_j + 1'b1) == w_nt);
    assign w_load     = (r_state == S_DONE) && !w_ob_busy;

    // Sequencer: walk taps, wait out the pipeline, hand off results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_smp) begin
                        r_state <= S_RUN;
                        r_j     <= '0;
                    end
                end
                S_RUN: begin
                    if (w_last_tap) begin
                        r_state <= S_FLUSH;
                        r_j     <= '0;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (r_j == TCNT_W'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!w_ob_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_dl_ctl.wr      = w_smp;
    assign w_dl_ctl.issue   = w_issue;
    assign w_mac_ctl.clear  = w_smp;
    assign w_mac_ctl.issue  = w_issue;

    msfir_dline #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dline (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_dl_ctl),
        .i_wr_data (i_in.sample),
        .i_stride  (w_st),
        .o_rd_data (w_smp_rd)
    );

    msfir_coef #(
        .NUM_FILTERS (NUM_FILTERS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_coef (
        .i_clk     (i_clk),
        .i_wr_en   (w_coef_we),
        .i_wr_lane (FI_W'(i_in.coef_filter)),
        .i_wr_addr (TAP_W'(i_in.coef_tap)),
        .i_wr_data (i_in.coef_value),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_j[TAP_W-1:0]),
        .o_rd_data (w_coef_rd)
    );

    msfir_mac #(
        .NUM_FILTERS (NUM_FILTERS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_smp   (w_smp_rd),
        .i_coef  (w_coef_rd),
        .o_res   (w_res)
    );

    msfir_obuf #(
        .NUM_FILTERS (NUM_FILTERS)
    ) u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_nf        (w_nf),
        .i_res       (w_res),
        .o_busy      (w_ob_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // A sample beat starts the tap walk at the first tap
    `MSFIR_ASSERT_NEXT(a_smp_starts_run, w_smp, (r_state == S_RUN) && (r_j == '0), "sample beat did not start tap walk")
    // A coefficient beat leaves the sequencer idle
    `MSFIR_ASSERT_NEXT(a_coef_stays_idle, w_in_acc && (i_in.op == OP_COEF), r_state == S_IDLE, "coefficient beat left idle")
    // The beat flagged last ends the burst of results
    `MSFIR_ASSERT_NEXT(a_last_ends_burst, o_out_valid && i_out_ready && o_out.last, !o_out_valid, "results continued after last beat")
    // Results are only loaded once the engine has finished
    `MSFIR_ASSERT_SAME(a_load_when_done, w_load, !o_in_ready && !w_issue, "result load outside done state")

endmodule
